/* rtl/core/tfp_pkg.sv */
// tfp_pkg: shared types, constants and helper functions of the tilt fusion pid core
// used by every module under rtl/core
package tfp_pkg;

  localparam int DATA_W       = 32;
  localparam int GAIN_W       = 31;
  localparam int DRIVE_W      = 12;
  localparam int CFG_ADDR_W   = 2;
  localparam int MUL_A_W      = 34;
  localparam int MUL_B_W      = 31;
  localparam int PROD_W       = MUL_A_W + MUL_B_W + 1;
  localparam int DIV_N_W      = 35;
  localparam int DIV_D_W      = 31;
  localparam int CORDIC_W     = 35;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX  = 12'd3000;
  localparam logic [GAIN_W-1:0]  W_LARGE    = 31'd32735;
  localparam logic [DIV_D_W-1:0] INTEG_DIV  = 31'd1000;
  localparam logic [DIV_N_W-1:0] WINDUP_NUM = 35'd26843545600;
  localparam logic [GAIN_W-1:0]  LIMIT_MAX  = 31'h7fffffff;

  localparam logic signed [DATA_W-1:0] DEG90  = 32'sd2949120;
  localparam logic signed [DATA_W-1:0] DEG180 = 32'sd5898240;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 31'd7864320;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 31'd2621440;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 31'd1310720;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_P   = 2'd0,
    CFG_GAIN_I   = 2'd1,
    CFG_GAIN_D   = 2'd2,
    CFG_SETPOINT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(32'sh7fffffff);
    lo = PROD_W'(32'sh80000000);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    case (i)
      4'd0:    atan_deg = 32'sd1474560;
      4'd1:    atan_deg = 32'sd870484;
      4'd2:    atan_deg = 32'sd459940;
      4'd3:    atan_deg = 32'sd233473;
      4'd4:    atan_deg = 32'sd117189;
      4'd5:    atan_deg = 32'sd58652;
      4'd6:    atan_deg = 32'sd29333;
      4'd7:    atan_deg = 32'sd14667;
      4'd8:    atan_deg = 32'sd7334;
      4'd9:    atan_deg = 32'sd3667;
      4'd10:   atan_deg = 32'sd1833;
      4'd11:   atan_deg = 32'sd917;
      4'd12:   atan_deg = 32'sd458;
      4'd13:   atan_deg = 32'sd229;
      4'd14:   atan_deg = 32'sd115;
      default: atan_deg = 32'sd57;
    endcase
  endfunction

endpackage

/* rtl/core/tilt_fusion_pid_pwm_core.sv */
// tilt_fusion_pid_pwm_core: top level, sequencer and state of the tilt fusion pid loop
// depends on tfp_pkg, tfp_cordic, tfp_serial_mul, tfp_serial_div
//
// One item per control tick: raw Y/Z acceleration and X gyro rate in, a drive level
// (0..3000) and the fused tilt angle out. Between acceptance and result each item goes
// through a 16-step cordic, four passes of the 31-bit serial multiplier
// (one bit per cycle) and a 35-bit serial divider that runs beside them for the windup
// limit and the integral term. A new item is taken only when the previous one is done;
// a result waits in the output register while the next item is already at work.
module tilt_fusion_pid_pwm_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // accel_y_raw[31:0], accel_z_raw[63:32], gyro_x_rate[95:64]
  input  logic [3*tfp_pkg::DATA_W-1:0]      s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // drive_level[11:0], tilt_estimate[43:12], zero pad[47:44]
  output logic [47:0]                       m_tdata,
  input  logic                              cfg_we,
  input  logic [tfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tfp_pkg::DATA_W-1:0]        cfg_data
);
  import tfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILT, ST_CSTART, ST_CWAIT, ST_M1S, ST_M1W, ST_ERR, ST_DER,
    ST_ES, ST_MPW, ST_MDS, ST_MDW, ST_DVW, ST_MIS, ST_MIW, ST_DONE
  } state_t;

  state_t state;

  logic [GAIN_W-1:0]        gain_p;
  logic [GAIN_W-1:0]        gain_i;
  logic [GAIN_W-1:0]        gain_d;
  logic signed [DATA_W-1:0] setpoint;

  logic signed [DATA_W-1:0] ay, az, gx;
  logic signed [DATA_W-1:0] fy, fz, fused, prev_err, integral;
  logic signed [DATA_W-1:0] err, deriv, angle;
  logic [GAIN_W-1:0]        limit;
  logic signed [PROD_W-1:0] pid;

  logic signed [DATA_W:0]   dy, dz;
  logic signed [DATA_W-1:0] gd;
  logic signed [MUL_A_W-1:0] t;
  logic signed [PROD_W-1:0] fuse_sum;
  logic signed [PROD_W-1:0] dd;
  logic signed [PROD_W-1:0] dm;
  logic [DATA_W:0]          err_mag;
  logic signed [DATA_W:0]   qv;
  logic signed [DATA_W:0]   integ;
  logic signed [DATA_W:0]   lim33;
  logic signed [PROD_W-1:0] pid_sh;
  logic [DRIVE_W-1:0]       drive;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic signed [PROD_W-1:0]  mul_q;
  unit_status_t              mul_st;

  logic                 div_start;
  logic [DIV_N_W-1:0]   div_n;
  logic [DIV_D_W-1:0]   div_d;
  logic [DIV_N_W-1:0]   div_q;
  unit_status_t         div_st;

  logic                     cor_start;
  logic signed [DATA_W-1:0] cor_angle;
  unit_status_t             cor_st;

  assign s_tready  = (state == ST_IDLE);
  assign cor_start = (state == ST_CSTART);
  assign mul_start = state inside {ST_M1S, ST_ES, ST_MDS, ST_MIS};
  assign div_start = (state == ST_CSTART) || (state == ST_ES);

  always_comb begin
    dy       = (DATA_W+1)'(ay) - (DATA_W+1)'(fy);
    dz       = (DATA_W+1)'(az) - (DATA_W+1)'(fz);
    gd       = gx >>> 10;
    t        = MUL_A_W'(fused) - MUL_A_W'(gd);
    mul_q    = mul_prod >>> 15;
    fuse_sum = mul_q + PROD_W'(angle >>> 10);
    dd       = PROD_W'(err) - PROD_W'(prev_err);
    dm       = (dd <<< 10) - (dd <<< 4) - (dd <<< 3);
    err_mag  = err[DATA_W-1] ? -(DATA_W+1)'(err) : (DATA_W+1)'(err);
    qv       = {1'b0, div_q[DATA_W-1:0]};
    if (err[DATA_W-1]) begin
      qv = -qv;
    end
    integ  = (DATA_W+1)'(integral) + qv;
    lim33  = {2'b00, limit};
    pid_sh = pid >>> 15;
    if (pid_sh[PROD_W-1]) begin
      drive = '0;
    end else if (pid_sh > PROD_W'(DRIVE_MAX)) begin
      drive = DRIVE_MAX;
    end else begin
      drive = pid_sh[DRIVE_W-1:0];
    end
    case (state)
      ST_M1S:  begin mul_a = t;                 mul_b = W_LARGE; end
      ST_ES:   begin mul_a = MUL_A_W'(err);     mul_b = gain_p;  end
      ST_MDS:  begin mul_a = MUL_A_W'(deriv);   mul_b = gain_d;  end
      ST_MIS:  begin mul_a = MUL_A_W'(integral); mul_b = gain_i; end
      default: begin mul_a = '0;                mul_b = '0;      end
    endcase
    if (state == ST_ES) begin
      div_n = DIV_N_W'(err_mag);
      div_d = INTEG_DIV;
    end else begin
      div_n = WINDUP_NUM;
      div_d = gain_i;
    end
  end

  tfp_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cor_start),
    .fy     (fy),
    .fz     (fz),
    .angle  (cor_angle),
    .status (cor_st)
  );

  tfp_serial_mul #(
    .WA (MUL_A_W),
    .WB (MUL_B_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .prod   (mul_prod),
    .status (mul_st)
  );

  tfp_serial_div #(
    .WN (DIV_N_W),
    .WD (DIV_D_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_n),
    .den    (div_d),
    .quo    (div_q),
    .status (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      gain_p   <= GAIN_P_RST;
      gain_i   <= GAIN_I_RST;
      gain_d   <= GAIN_D_RST;
      setpoint <= '0;
      fy       <= '0;
      fz       <= '0;
      fused    <= '0;
      prev_err <= '0;
      integral <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_P:   gain_p   <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_I:   gain_i   <= cfg_data[GAIN_W-1:0];
          CFG_GAIN_D:   gain_d   <= cfg_data[GAIN_W-1:0];
          CFG_SETPOINT: setpoint <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ay    <= s_tdata[DATA_W-1:0];
            az    <= s_tdata[2*DATA_W-1:DATA_W];
            gx    <= s_tdata[3*DATA_W-1:2*DATA_W];
            state <= ST_FILT;
          end
        end
        ST_FILT: begin
          fy    <= DATA_W'((DATA_W+1)'(fy) + (dy >>> 3));
          fz    <= DATA_W'((DATA_W+1)'(fz) + (dz >>> 3));
          state <= ST_CSTART;
        end
        ST_CSTART: state <= ST_CWAIT;
        ST_CWAIT: begin
          if (cor_st.done) begin
            angle <= cor_angle;
            state <= ST_M1S;
          end
        end
        ST_M1S: state <= ST_M1W;
        ST_M1W: begin
          if (mul_st.done) begin
            fused <= sat32(fuse_sum);
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          err   <= sat32(PROD_W'(setpoint) - PROD_W'(fused));
          state <= ST_DER;
        end
        ST_DER: begin
          if (!div_st.busy) begin
            deriv    <= sat32(dm);
            prev_err <= err;
            limit    <= (div_q > DIV_N_W'(LIMIT_MAX)) ? LIMIT_MAX : div_q[GAIN_W-1:0];
            state    <= ST_ES;
          end
        end
        ST_ES: begin
          pid   <= '0;
          state <= ST_MPW;
        end
        ST_MPW: begin
          if (mul_st.done) begin
            pid   <= pid + mul_q;
            state <= ST_MDS;
          end
        end
        ST_MDS: state <= ST_MDW;
        ST_MDW: begin
          if (mul_st.done) begin
            pid   <= pid + mul_q;
            state <= ST_DVW;
          end
        end
        ST_DVW: begin
          if (!div_st.busy) begin
            if (integ > lim33) begin
              integral <= DATA_W'(lim33);
            end else if (integ < -lim33) begin
              integral <= DATA_W'(-lim33);
            end else begin
              integral <= integ[DATA_W-1:0];
            end
            state <= ST_MIS;
          end
        end
        ST_MIS: state <= ST_MIW;
        ST_MIW: begin
          if (mul_st.done) begin
            pid   <= pid + mul_q;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0000, fused, drive};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[DRIVE_W-1:0] <= DRIVE_MAX))
    else $error("drive level above saturation limit");

  a_integ_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIS) |-> ((DATA_W+1)'(integral) <= lim33 &&
                           (DATA_W+1)'(integral) >= -lim33))
    else $error("integral outside windup limit");

endmodule

/* rtl/core/tfp_serial_mul.sv */
// tfp_serial_mul: signed by unsigned shift-add multiplier, one multiplier bit per cycle
// depends on tfp_pkg
module tfp_serial_mul #(
  parameter int WA = tfp_pkg::MUL_A_W,
  parameter int WB = tfp_pkg::MUL_B_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [WA-1:0]         a,
  input  logic        [WB-1:0]         b,
  output logic signed [WA+WB:0]        prod,
  output tfp_pkg::unit_status_t        status
);
  import tfp_pkg::*;

  localparam int CW = $clog2(WB);

  logic signed [WA-1:0] mcand;
  logic signed [WA:0]   acc;
  logic        [WB-1:0] lo;
  logic        [CW-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic signed [WA:0]   sum;

  assign sum = acc + (lo[0] ? (WA+1)'(mcand) : '0);
  assign prod = {acc, lo};
  assign status = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        mcand <= a;
        acc   <= '0;
        lo    <= b;
      end else if (busy) begin
        acc <= sum >>> 1;
        lo  <= {sum[0], lo[WB-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/tfp_serial_div.sv */
// tfp_serial_div: unsigned restoring divider, one quotient bit per cycle
// depends on tfp_pkg
module tfp_serial_div #(
  parameter int WN = tfp_pkg::DIV_N_W,
  parameter int WD = tfp_pkg::DIV_D_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [WN-1:0]         num,
  input  logic [WD-1:0]         den,
  output logic [WN-1:0]         quo,
  output tfp_pkg::unit_status_t status
);
  import tfp_pkg::*;

  localparam int CW = $clog2(WN);

  logic [WN-1:0] q;
  logic [WD-1:0] rem;
  logic [WD-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [WD:0]   trial;
  logic          fits;

  assign trial  = {rem, q[WN-1]};
  assign fits   = trial >= {1'b0, dsr};
  assign quo    = q;
  assign status = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= num;
        rem  <= '0;
        dsr  <= den;
      end else if (busy) begin
        rem <= fits ? WD'(trial - {1'b0, dsr}) : trial[WD-1:0];
        q   <= {q[WN-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/tfp_cordic.sv */
// tfp_cordic: vectoring cordic, one rotation per cycle, gives atan2 angle plus 90 degrees
// depends on tfp_pkg (angle table, degree constants)
module tfp_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tfp_pkg::DATA_W-1:0]   fy,
  input  logic signed [tfp_pkg::DATA_W-1:0]   fz,
  output logic signed [tfp_pkg::DATA_W-1:0]   angle,
  output tfp_pkg::unit_status_t               status
);
  import tfp_pkg::*;

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [DATA_W-1:0]   z;
  logic        [STEP_W-1:0]   cnt;
  logic                       busy;
  logic                       done;
  logic signed [CORDIC_W-1:0] x0;
  logic signed [CORDIC_W-1:0] y0;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;

  assign x0 = CORDIC_W'(fz);
  assign y0 = -CORDIC_W'(fy);
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign angle = z + DEG90;
  assign status = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        if (x0 < 0) begin
          x <= -x0;
          y <= -y0;
          z <= (y0 >= 0) ? DEG180 : -DEG180;
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_deg(cnt);
        end else if (y < 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_deg(cnt);
        end
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/sv/tb_tilt_fusion_pid_pwm_core.sv */
// tb_tilt_fusion_pid_pwm_core: self-checking testbench of the tilt fusion pid core
// depends on tfp_pkg and tilt_fusion_pid_pwm_core; a class predicts each tick and
// checks drive level and fused angle in order under random source gaps and sink stalls
module tb_tilt_fusion_pid_pwm_core;
  import tfp_pkg::*;

  localparam longint W_SMALL_Q = 32;
  localparam longint DRIVE_TOP = 3000;
  localparam longint SCALE_K = 1000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint ATAN_Q [16] = '{1474560, 870484, 459940, 233473, 117189, 58652,
    29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  class tilt_loop_scoreboard;
    logic [30:0] kp, ki, kd;
    logic signed [31:0] sp;
    logic signed [31:0] fy, fz, fused, prev_err, integ;
    logic [47:0] pending[$];
    int errors;

    function new();
      kp = GAIN_P_RST;
      ki = GAIN_I_RST;
      kd = GAIN_D_RST;
      sp = 0;
      fy = 0;
      fz = 0;
      fused = 0;
      prev_err = 0;
      integ = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] v);
      case (idx)
        CFG_GAIN_P: kp = v[30:0];
        CFG_GAIN_I: ki = v[30:0];
        CFG_GAIN_D: kd = v[30:0];
        CFG_SETPOINT: sp = v;
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > I32_MAX) return I32_MAX;
      if (v < I32_MIN) return I32_MIN;
      return v;
    endfunction

    function longint tilt_deg(longint y_in, longint z_in);
      longint x, y, z, xs, ys;
      x = z_in;
      y = -y_in;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_Q[i];
        end else if (y < 0) begin
          x -= ys; y += xs; z -= ATAN_Q[i];
        end
      end
      return z + longint'(DEG90);
    endfunction

    function void note_input(logic [95:0] d);
      logic signed [31:0] ay, az, gx, err, deriv;
      longint angle, gd, lim, acc, pid, drv;
      ay = d[31:0];
      az = d[63:32];
      gx = d[95:64];
      fy = 32'(longint'(fy) + ((longint'(ay) - longint'(fy)) >>> 3));
      fz = 32'(longint'(fz) + ((longint'(az) - longint'(fz)) >>> 3));
      angle = tilt_deg(fy, fz);
      gd = (longint'(gx) * W_SMALL_Q) >>> 15;
      fused = 32'(sat((((longint'(fused) - gd) * longint'(W_LARGE)) >>> 15)
                      + ((angle * W_SMALL_Q) >>> 15)));
      err = 32'(sat(longint'(sp) - longint'(fused)));
      deriv = 32'(sat((longint'(err) - longint'(prev_err)) * SCALE_K));
      prev_err = err;
      if (ki == 0) lim = I32_MAX;
      else begin
        lim = (longint'(25) <<< 30) / longint'(ki);
        if (lim > I32_MAX) lim = I32_MAX;
      end
      acc = longint'(integ) + longint'(err) / SCALE_K;
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ = 32'(acc);
      pid = ((longint'(kp) * longint'(err)) >>> 15) + ((longint'(ki) * longint'(integ)) >>> 15)
          + ((longint'(kd) * longint'(deriv)) >>> 15);
      drv = pid >>> 15;
      if (drv < 0) drv = 0;
      if (drv > DRIVE_TOP) drv = DRIVE_TOP;
      pending.push_back({4'b0, fused, drv[11:0]});
    endfunction

    function void check_result(logic [47:0] d);
      logic [47:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (d[11:0] !== want[11:0]) begin
        $display("%0t: drive_level expected %0d actual %0d", $time, want[11:0], d[11:0]);
        errors++;
      end
      if (d[43:12] !== want[43:12]) begin
        $display("%0t: tilt_estimate expected %0d actual %0d", $time,
                 $signed(want[43:12]), $signed(d[43:12]));
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  tilt_loop_scoreboard sb = new();
  int stall_mode = 0;
  int cyc = 0;

  tilt_fusion_pid_pwm_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // sink stall pattern is redrawn among four modes: always ready, random, mostly stalled, alternating
  always @(negedge clk) begin
    cyc++;
    if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= ($urandom_range(0, 9) == 0);
      default: m_tready <= ((cyc / 37) % 2 == 0);
    endcase
  end

  task automatic write_reg(cfg_index_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic send_item(logic [31:0] ay, logic [31:0] az, logic [31:0] gx);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {gx, az, ay};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] pick_accel(bit wide);
    int m;
    m = $urandom_range(0, 9);
    if (wide || m == 0) return $urandom();
    if (m == 1) return (m % 2) ? 32'h7fffffff : 32'h80000000;
    return $urandom_range(0, 98304) - 49152;
  endfunction

  function automatic logic [31:0] pick_rate(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return $urandom();
    return $urandom_range(0, 2000000) - 1000000;
  endfunction

  task automatic run_random(int count);
    int burst;
    bit wide;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      wide = ($urandom_range(0, 4) == 0);
      send_item(pick_accel(wide), pick_accel(wide), pick_rate(wide));
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 1)) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
          repeat ($urandom_range(0, 250)) @(negedge clk);
        end
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero axes, extremes, quadrant edges, error and derivative saturation
    send_item(0, 0, 0);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000, 32'h80000000);
    send_item(32'h7fffffff, 32'h80000000, 0);
    send_item(32'h80000000, 32'h80000000, 32'h7fffffff);
    send_item(0, 32'h80000000, 32'h80000000);
    send_item(32'hffff8000, 32'h00008000, 0);
    send_item(32'h00008000, 32'hffff8000, 32'h00100000);
    send_item(0, 32'h00008000, 0);
    wait_idle();
    write_reg(CFG_SETPOINT, 32'h7fffffff);
    write_reg(CFG_GAIN_D, 32'hffffffff);
    send_item(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    wait_idle();
    write_reg(CFG_SETPOINT, 32'h80000000);
    write_reg(CFG_GAIN_I, 0);
    write_reg(CFG_GAIN_P, 32'h7fffffff);
    send_item(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_item(0, 0, 32'h80000000);
    send_item(0, 0, 0);
    wait_idle();
    write_reg(CFG_GAIN_I, 1);
    write_reg(CFG_GAIN_P, 0);
    write_reg(CFG_GAIN_D, 0);
    write_reg(CFG_SETPOINT, 0);
    send_item(32'h00004000, 32'h00008000, 0);
    send_item(32'hffffc000, 32'h00008000, 0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_GAIN_P, GAIN_P_RST);
          write_reg(CFG_GAIN_I, GAIN_I_RST);
          write_reg(CFG_GAIN_D, GAIN_D_RST);
          write_reg(CFG_SETPOINT, 0);
        end
        1: begin
          write_reg(CFG_GAIN_P, 32'hffffffff);
          write_reg(CFG_GAIN_I, 32'h7fffffff);
          write_reg(CFG_GAIN_D, 32'h7fffffff);
        end
        2: begin
          write_reg(CFG_GAIN_I, 0);
          write_reg(CFG_SETPOINT, 32'h7fffffff);
        end
        3: begin
          write_reg(CFG_GAIN_I, 1);
          write_reg(CFG_SETPOINT, 32'h80000000);
        end
        default: begin
          write_reg(CFG_GAIN_P, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 23));
          write_reg(CFG_GAIN_I, $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 1 << 23));
          write_reg(CFG_GAIN_D, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 22));
          write_reg(CFG_SETPOINT, $urandom_range(0, 1) ? $urandom()
                                  : $urandom_range(0, 6000000) - 3000000);
        end
      endcase
      run_random(250);
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* files.f */
rtl/core/tfp_pkg.sv
rtl/core/tfp_serial_mul.sv
rtl/core/tfp_serial_div.sv
rtl/core/tfp_cordic.sv
rtl/core/tilt_fusion_pid_pwm_core.sv
tb/sv/tb_tilt_fusion_pid_pwm_core.sv
